@@ rtl/i2c_eeprom_slave_emulator_defines.svh @@
// Assertion macros used by the RTL file i2c_eeprom_slave_emulator.sv.
`ifndef I2C_EEPROM_SLAVE_EMULATOR_DEFINES_SVH
`define I2C_EEPROM_SLAVE_EMULATOR_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define I2CEE_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent holds at the edge where the antecedent holds.
`define I2CEE_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cee_pkg.sv @@
`default_nettype none

package i2cee_pkg;

  localparam int unsigned MEM_BYTES_DEF  = 512;
  localparam int unsigned PAGE_BYTES_DEF = 256;

  localparam int ADDR_W    = 16;
  localparam int LEN_W     = 9;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 3;
  localparam int SEEN_W    = 2;
  localparam int MOD_STEPS = 8;
  localparam int MOD_W     = ADDR_W + MOD_STEPS + 1;

  localparam logic [MODE_W-1:0] MODE_ADDR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RX   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TX   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK = 3'd4;

  localparam logic [SEEN_W-1:0] ADDR_BYTES = 2'd2;

  // Remainder of a 16-bit address by a modulus of at least 256, so the
  // quotient has at most eight bits and eight compare-subtract steps suffice.
  function automatic logic [ADDR_W-1:0] mod_mem(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W:0]   m);
    logic [MOD_W-1:0] r;
    logic [MOD_W-1:0] d;
    r = MOD_W'(a);
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      d = MOD_W'(m) << j;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/i2cee_if.sv @@
`default_nettype none

interface i2cee_in_if import i2cee_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              dir_is_write;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output mode, output dir_is_write, output rx_byte,
                  input ready);
  modport sink (input valid, input mode, input dir_is_write, input rx_byte,
                output ready);
endinterface

interface i2cee_out_if import i2cee_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ack;
  logic [BYTE_W-1:0] tx_byte;
  logic              busy_res;

  modport source (output valid, output ack, output tx_byte, output busy_res,
                  input ready);
  modport sink (input valid, input ack, input tx_byte, input busy_res,
                output ready);
endinterface

`default_nettype wire

@@ rtl/i2c_eeprom_slave_emulator.sv @@
// Address match, received byte, stop, idle tick and unused modes go from S_IDLE straight to S_DONE.
// Transmit request: S_RADR does the registered read of the byte memory, S_RDAT takes the byte, then S_DONE.
// Service tick with a commit pending: S_CSTART, then S_COPY moves one byte per cycle
// through the page buffer read port and the byte memory write port.
// Synchronous reset starts a clearing pass that writes i mod 256 into byte i; no
// request is taken until it ends. The result register frees the input side.
`default_nettype none
`include "i2c_eeprom_slave_emulator_defines.svh"

module i2c_eeprom_slave_emulator import i2cee_pkg::*; #(
  parameter int unsigned MEM_BYTES  = MEM_BYTES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  i2cee_in_if.sink    in_req,
  i2cee_out_if.source out_res
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam logic [ADDR_W:0]   MEM_LIM  = (ADDR_W + 1)'(MEM_BYTES);
  localparam logic [AW-1:0]     MEM_LAST = AW'(MEM_BYTES - 1);
  localparam logic [PW-1:0]     PAGE_LAST = PW'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] PAGE_CNT = ADDR_W'(PAGE_BYTES);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RADR   = 7'b0000100,
    S_RDAT   = 7'b0001000,
    S_CSTART = 7'b0010000,
    S_COPY   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [ADDR_W-1:0] dc_r, dc_nxt;
  logic [PW-1:0]     slot_r, slot_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [LEN_W-1:0]  pend_len_r, pend_len_nxt;
  logic              busy_r, busy_nxt;
  logic [LEN_W-1:0]  rcnt_r, rcnt_nxt;
  logic              wv_r, wv_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic              res_ack_r, res_ack_nxt;
  logic [BYTE_W-1:0] res_tx_r, res_tx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ack_r, out_ack_nxt;
  logic [BYTE_W-1:0] out_tx_r, out_tx_nxt;
  logic              out_busy_r, out_busy_nxt;

  logic [BYTE_W-1:0] mem [MEM_BYTES];
  logic [BYTE_W-1:0] pbuf [PAGE_BYTES];
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] pbuf_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic              pb_we;
  logic              pb_re;
  logic [PW-1:0]     pb_raddr;

  logic              acc;
  logic              acc_stop;
  logic [ADDR_W-1:0] ptr_mod;
  logic [ADDR_W-1:0] pend_mod;
  logic [ADDR_W:0]   ptr_inc;
  logic [LEN_W-1:0]  stop_len;

  assign in_req.ready     = (state_r == S_IDLE);
  assign acc              = in_req.valid && (state_r == S_IDLE);
  assign acc_stop         = acc && (in_req.mode == MODE_STOP);
  assign out_res.valid    = out_valid_r;
  assign out_res.ack      = out_ack_r;
  assign out_res.tx_byte  = out_tx_r;
  assign out_res.busy_res = out_busy_r;

  assign ptr_mod  = mod_mem(ptr_r, MEM_LIM);
  assign pend_mod = mod_mem(pend_addr_r, MEM_LIM);
  assign ptr_inc  = {1'b0, ptr_r} + (ADDR_W + 1)'(1);
  assign stop_len = (dc_r > PAGE_CNT) ? LEN_W'(PAGE_BYTES) : dc_r[LEN_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ptr_nxt       = ptr_r;
    seen_nxt      = seen_r;
    dc_nxt        = dc_r;
    slot_nxt      = slot_r;
    pend_addr_nxt = pend_addr_r;
    pend_len_nxt  = pend_len_r;
    busy_nxt      = busy_r;
    rcnt_nxt      = rcnt_r;
    wv_nxt        = wv_r;
    waddr_nxt     = waddr_r;
    res_ack_nxt   = res_ack_r;
    res_tx_nxt    = res_tx_r;
    out_valid_nxt = out_valid_r;
    out_ack_nxt   = out_ack_r;
    out_tx_nxt    = out_tx_r;
    out_busy_nxt  = out_busy_r;
    mem_we        = 1'b0;
    mem_waddr     = waddr_r;
    mem_wdata     = pbuf_q;
    mem_re        = 1'b0;
    pb_we         = 1'b0;
    pb_re         = 1'b0;
    pb_raddr      = rcnt_r[PW-1:0];

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_r[BYTE_W-1:0];
        if (clr_r == MEM_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (acc) begin
          res_ack_nxt = 1'b1;
          res_tx_nxt  = '0;
          state_nxt   = S_DONE;
          case (in_req.mode)
            MODE_ADDR: begin
              if (in_req.dir_is_write && busy_r) begin
                res_ack_nxt = 1'b0;
              end else begin
                seen_nxt = '0;
                dc_nxt   = '0;
                slot_nxt = '0;
              end
            end
            MODE_RX: begin
              if (seen_r < ADDR_BYTES) begin
                if (seen_r == '0) begin
                  ptr_nxt = {ptr_r[ADDR_W-1:BYTE_W], in_req.rx_byte};
                end else begin
                  ptr_nxt = {in_req.rx_byte, ptr_r[BYTE_W-1:0]};
                end
                seen_nxt = seen_r + SEEN_W'(1);
              end else begin
                pb_we  = 1'b1;
                dc_nxt = dc_r + ADDR_W'(1);
                if (dc_r == '1 || slot_r == PAGE_LAST) begin
                  slot_nxt = '0;
                end else begin
                  slot_nxt = slot_r + PW'(1);
                end
              end
            end
            MODE_TX: begin
              state_nxt = S_RADR;
            end
            MODE_STOP: begin
              if (dc_r != '0) begin
                pend_addr_nxt = ptr_r;
                pend_len_nxt  = stop_len;
                ptr_nxt       = ptr_r + ADDR_W'(stop_len);
                seen_nxt      = '0;
                dc_nxt        = '0;
                slot_nxt      = '0;
                busy_nxt      = 1'b1;
              end
            end
            MODE_TICK: begin
              if (busy_r) begin
                state_nxt = S_CSTART;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RADR: begin
        mem_re = 1'b1;
        if (ptr_inc >= MEM_LIM) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_inc[ADDR_W-1:0];
        end
        state_nxt = S_RDAT;
      end
      S_RDAT: begin
        res_tx_nxt = mem_q;
        state_nxt  = S_DONE;
      end
      S_CSTART: begin
        waddr_nxt = pend_mod[AW-1:0];
        rcnt_nxt  = '0;
        wv_nxt    = 1'b0;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        if (rcnt_r != pend_len_r) begin
          pb_re    = 1'b1;
          rcnt_nxt = rcnt_r + LEN_W'(1);
          wv_nxt   = 1'b1;
        end else begin
          wv_nxt = 1'b0;
        end
        if (wv_r) begin
          mem_we = 1'b1;
          if (waddr_r == MEM_LAST) begin
            waddr_nxt = '0;
          end else begin
            waddr_nxt = waddr_r + AW'(1);
          end
        end
        if (rcnt_r == pend_len_r && !wv_r) begin
          busy_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_ack_nxt   = res_ack_r;
          out_tx_nxt    = res_tx_r;
          out_busy_nxt  = busy_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[ptr_mod[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pbuf[slot_r] <= in_req.rx_byte;
    end
    if (pb_re) begin
      pbuf_q <= pbuf[pb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      ptr_r       <= '0;
      seen_r      <= '0;
      dc_r        <= '0;
      slot_r      <= '0;
      pend_addr_r <= '0;
      pend_len_r  <= '0;
      busy_r      <= 1'b0;
      rcnt_r      <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ptr_r       <= ptr_nxt;
      seen_r      <= seen_nxt;
      dc_r        <= dc_nxt;
      slot_r      <= slot_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_len_r  <= pend_len_nxt;
      busy_r      <= busy_nxt;
      rcnt_r      <= rcnt_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    waddr_r    <= waddr_nxt;
    res_ack_r  <= res_ack_nxt;
    res_tx_r   <= res_tx_nxt;
    out_ack_r  <= out_ack_nxt;
    out_tx_r   <= out_tx_nxt;
    out_busy_r <= out_busy_nxt;
  end

  `I2CEE_IMPLY(a_mem_addr_range, mem_we, {{(32 - AW){1'b0}}, mem_waddr} < MEM_BYTES, "memory write address out of range")
  `I2CEE_IMPLY(a_copy_bound, state_r == S_COPY, rcnt_r <= pend_len_r, "page copy ran past the pending length")
  `I2CEE_IMPLY(a_busy_from_stop, $rose(busy_r), $past(acc_stop), "commit pending set without a stop request")
  `I2CEE_ALWAYS(a_pending_len, !busy_r || (pend_len_r != '0 && pend_len_r <= LEN_W'(PAGE_BYTES)), "pending length out of range while busy")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import i2cee_pkg::*; ();

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_IDLE     = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = PAGE_BYTES_DEF + 40;
  localparam int RANDOM_ITEMS = 1430;
  localparam int RUN_LIMIT    = 3_000_000;
  localparam int LONG_PAGE    = PAGE_BYTES_DEF + 44;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
  localparam logic              DIR_READ       = 1'b0;
  localparam logic              DIR_WRITE      = 1'b1;

  typedef struct packed {
    logic              ack;
    logic [BYTE_W-1:0] tx_byte;
    logic              busy;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cee_in_if  in_req_if ();
  i2cee_out_if out_res_if ();

  i2c_eeprom_slave_emulator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_res (out_res_if)
  );

  logic [BYTE_W-1:0] eeprom_mem [MEM_BYTES_DEF];
  logic [BYTE_W-1:0] page_buf [PAGE_BYTES_DEF];
  logic [ADDR_W-1:0] addr_ptr;
  logic [SEEN_W-1:0] addr_seen;
  logic [15:0]       byte_count;
  logic [ADDR_W-1:0] commit_addr;
  logic [LEN_W-1:0]  commit_len;
  logic              commit_busy;

  reply_t replies_due [$];
  int     error_count  = 0;
  int     cycle_count  = 0;
  int     items_sent   = 0;
  bit     idle_on      = 1'b1;
  bit     hold_request = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  function automatic void eeprom_reset();
    for (int i = 0; i < MEM_BYTES_DEF; i++) begin
      eeprom_mem[i] = BYTE_W'(i);
    end
    for (int i = 0; i < PAGE_BYTES_DEF; i++) begin
      page_buf[i] = '0;
    end
    addr_ptr    = '0;
    addr_seen   = '0;
    byte_count  = '0;
    commit_addr = '0;
    commit_len  = '0;
    commit_busy = 1'b0;
  endfunction

  function automatic reply_t eeprom_event(input logic [MODE_W-1:0] mode, input logic dir_wr,
                                          input logic [BYTE_W-1:0] rx);
    reply_t      r;
    int unsigned next_ptr;
    int unsigned len;
    r.ack     = 1'b1;
    r.tx_byte = '0;
    case (mode)
      MODE_ADDR: begin
        if (dir_wr && commit_busy) begin
          r.ack = 1'b0;
        end else begin
          addr_seen  = '0;
          byte_count = '0;
        end
      end
      MODE_RX: begin
        if (addr_seen < ADDR_BYTES) begin
          if (addr_seen == '0) begin
            addr_ptr[BYTE_W-1:0] = rx;
          end else begin
            addr_ptr[ADDR_W-1:BYTE_W] = rx;
          end
          addr_seen = addr_seen + 1'b1;
        end else begin
          page_buf[byte_count % PAGE_BYTES_DEF] = rx;
          byte_count = byte_count + 1'b1;
        end
      end
      MODE_TX: begin
        r.tx_byte = eeprom_mem[addr_ptr % MEM_BYTES_DEF];
        next_ptr  = addr_ptr + 1;
        addr_ptr  = (next_ptr >= MEM_BYTES_DEF) ? '0 : ADDR_W'(next_ptr);
      end
      MODE_STOP: begin
        if (byte_count != 0) begin
          len         = (byte_count > PAGE_BYTES_DEF) ? PAGE_BYTES_DEF : byte_count;
          commit_addr = addr_ptr;
          commit_len  = LEN_W'(len);
          addr_ptr    = ADDR_W'(addr_ptr + len);
          addr_seen   = '0;
          byte_count  = '0;
          commit_busy = 1'b1;
        end
      end
      MODE_TICK: begin
        if (commit_busy) begin
          for (int i = 0; i < commit_len; i++) begin
            eeprom_mem[(commit_addr + i) % MEM_BYTES_DEF] = page_buf[i];
          end
          commit_busy = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.busy = commit_busy;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic rand_dir();
    return $urandom_range(0, 1) != 0;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return ADDR_W'($urandom);
    end else if (pick == 1) begin
      return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 15));
    end
    return ADDR_W'($urandom_range(0, 2 * MEM_BYTES_DEF - 1));
  endfunction

  // Valid stays high when the next request follows without a gap.
  task automatic send_req(input logic [MODE_W-1:0] mode, input logic dir_wr,
                          input logic [BYTE_W-1:0] rx);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_if.valid        <= 1'b1;
    in_req_if.mode         <= mode;
    in_req_if.dir_is_write <= dir_wr;
    in_req_if.rx_byte      <= rx;
    do @(posedge clk); while (in_req_if.ready !== 1'b1);
    replies_due.push_back(eeprom_event(mode, dir_wr, rx));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_req_if.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic point_to(input logic [ADDR_W-1:0] addr);
    send_req(MODE_ADDR, DIR_WRITE, rand_byte());
    send_req(MODE_RX, rand_dir(), addr[BYTE_W-1:0]);
    send_req(MODE_RX, rand_dir(), addr[ADDR_W-1:BYTE_W]);
  endtask

  task automatic test_reset_image();
    point_to(16'h01FF);
    send_req(MODE_ADDR, DIR_READ, 8'h00);
    repeat (3) send_req(MODE_TX, DIR_WRITE, 8'hFF);
    send_req(MODE_STOP, DIR_READ, 8'h00);
  endtask

  task automatic test_spare_modes();
    send_req(MODE_SPARE_LO, DIR_WRITE, 8'hFF);
    send_req(MODE_SPARE_MID, DIR_READ, 8'h00);
    send_req(MODE_SPARE_HI, DIR_WRITE, 8'hA5);
    send_req(MODE_TICK, DIR_READ, 8'h00);
  endtask

  task automatic test_busy_commit();
    point_to(16'hFE00);
    send_req(MODE_RX, DIR_READ, 8'h00);
    send_req(MODE_RX, DIR_WRITE, 8'hFF);
    send_req(MODE_RX, DIR_READ, 8'h5A);
    send_req(MODE_STOP, DIR_READ, 8'h00);
    send_req(MODE_ADDR, DIR_WRITE, 8'h00);
    send_req(MODE_STOP, DIR_READ, 8'h00);
    send_req(MODE_ADDR, DIR_READ, 8'h00);
    send_req(MODE_TX, DIR_READ, 8'h00);
    send_req(MODE_TICK, DIR_READ, 8'h00);
    send_req(MODE_TICK, DIR_WRITE, 8'hFF);
    send_req(MODE_TX, DIR_READ, 8'h00);
  endtask

  task automatic test_stop_while_busy();
    point_to(16'h0010);
    send_req(MODE_RX, DIR_READ, 8'h11);
    send_req(MODE_STOP, DIR_READ, 8'h00);
    send_req(MODE_RX, DIR_READ, 8'h20);
    send_req(MODE_RX, DIR_READ, 8'h00);
    send_req(MODE_RX, DIR_READ, 8'h22);
    send_req(MODE_RX, DIR_READ, 8'h33);
    send_req(MODE_STOP, DIR_READ, 8'h00);
    send_req(MODE_TICK, DIR_READ, 8'h00);
  endtask

  task automatic test_long_page();
    point_to(16'h01F0);
    repeat (LONG_PAGE) send_req(MODE_RX, rand_dir(), rand_byte());
    send_req(MODE_STOP, rand_dir(), rand_byte());
    send_req(MODE_TICK, rand_dir(), rand_byte());
    point_to(16'h01F0);
    send_req(MODE_ADDR, DIR_READ, rand_byte());
    repeat (24) send_req(MODE_TX, rand_dir(), rand_byte());
    send_req(MODE_STOP, rand_dir(), rand_byte());
  endtask

  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    point_to(random_address());
    send_req(MODE_ADDR, DIR_READ, rand_byte());
    repeat (40) send_req(MODE_TX, rand_dir(), rand_byte());
    send_req(MODE_STOP, rand_dir(), rand_byte());
    idle_on = 1'b1;
  endtask

  task automatic random_write();
    int n;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      n = 0;
    end else if (pick == 1) begin
      n = $urandom_range(PAGE_BYTES_DEF - 4, PAGE_BYTES_DEF + 12);
    end else begin
      n = $urandom_range(1, 12);
    end
    point_to(random_address());
    repeat (n) send_req(MODE_RX, rand_dir(), rand_byte());
    if ($urandom_range(0, 9) != 0) begin
      send_req(MODE_STOP, rand_dir(), rand_byte());
    end
    if ($urandom_range(0, 3) != 0) begin
      send_req(MODE_TICK, rand_dir(), rand_byte());
    end
  endtask

  task automatic random_read(input bit set_addr);
    if (set_addr) begin
      point_to(random_address());
    end
    send_req(MODE_ADDR, DIR_READ, rand_byte());
    repeat ($urandom_range(1, 8)) send_req(MODE_TX, rand_dir(), rand_byte());
    send_req(MODE_STOP, rand_dir(), rand_byte());
  endtask

  task automatic random_noise();
    repeat ($urandom_range(1, 6)) send_req(MODE_W'($urandom), rand_dir(), rand_byte());
  endtask

  task automatic test_random_traffic();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          random_write();
        end
        4, 5, 6: begin
          random_read(1'b1);
        end
        7: begin
          random_read(1'b0);
        end
        default: begin
          random_noise();
        end
      endcase
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int hold;
    out_res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_request) begin
        hold += HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        out_res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_res_if.ready <= 1'b1;
      do @(posedge clk); while (out_res_if.valid !== 1'b1 || rst_n !== 1'b1);
    end
  end

  function automatic void check_field(input string field, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n === 1'b1 && out_res_if.valid === 1'b1 && out_res_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual ack %0h tx %0h busy %0h",
                 $time, out_res_if.ack, out_res_if.tx_byte, out_res_if.busy_res);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("ack", BYTE_W'(want.ack), BYTE_W'(out_res_if.ack));
        check_field("tx_byte", want.tx_byte, out_res_if.tx_byte);
        check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(out_res_if.busy_res));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n                  <= 1'b0;
    in_req_if.valid        <= 1'b0;
    in_req_if.mode         <= MODE_ADDR;
    in_req_if.dir_is_write <= DIR_READ;
    in_req_if.rx_byte      <= '0;
    eeprom_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_image();
    test_spare_modes();
    test_busy_commit();
    test_stop_while_busy();
    test_long_page();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/i2cee_pkg.sv
rtl/i2cee_if.sv
rtl/i2c_eeprom_slave_emulator.sv
sim/tb_top.sv
